FILE: rtl/alhtp_pkg.sv
`timescale 1ns / 1ps
package alhtp_pkg;

	localparam int unsigned PULSE_W  = 12;
	localparam int unsigned STICK_W  = 13;
	localparam int unsigned GAIN_W   = 15;
	localparam int unsigned NERR_W   = 5;
	localparam int unsigned CFG_W    = 16;
	localparam int unsigned IDX_W    = 3;

	localparam logic [PULSE_W-1:0] PULSE_MIN = 12'd2000;
	localparam logic [PULSE_W-1:0] PULSE_MAX = 12'd4000;
	localparam int                 DEADBAND      = 150;
	localparam int                 HEIGHT_MARGIN = 10;
	localparam int unsigned        FILT_SHIFT    = 12;
	localparam int unsigned        STICK_SHIFT   = 11;

	localparam logic [IDX_W-1:0] REG_TRIM     = 3'd0;
	localparam logic [IDX_W-1:0] REG_REVERSED = 3'd1;
	localparam logic [IDX_W-1:0] REG_MAX_THR  = 3'd2;
	localparam logic [IDX_W-1:0] REG_THR_PH   = 3'd3;
	localparam logic [IDX_W-1:0] REG_GAIN     = 3'd4;
	localparam logic [IDX_W-1:0] REG_PIT_MAX  = 3'd5;
	localparam logic [IDX_W-1:0] REG_PIT_ZERO = 3'd6;
	localparam logic [IDX_W-1:0] REG_PIT_PH   = 3'd7;

	localparam logic [1:0] CLS_BELOW  = 2'd0;
	localparam logic [1:0] CLS_ABOVE  = 2'd1;
	localparam logic [1:0] CLS_MARGIN = 2'd2;

	typedef struct packed {
		logic load;
		logic step;
	} mul_ctl_t;

	function automatic logic [PULSE_W-1:0] sat_pulse(input logic [15:0] v);
		logic [PULSE_W-1:0] r;
		if (v < {4'd0, PULSE_MIN}) begin
			r = PULSE_MIN;
		end else if (v > {4'd0, PULSE_MAX}) begin
			r = PULSE_MAX;
		end else begin
			r = v[PULSE_W-1:0];
		end
		return r;
	endfunction

endpackage

FILE: rtl/altitude_hold_throttle_pitch.sv
// altitude hold throttle and pitch, one item at a time through a bit-serial multiplier
// with hold enabled an item passes the stick, target multiply, error, error multiply,
// accumulate, update and output steps; with hold off it goes straight to output; no new
// item is taken until the last has left the output step, and a stalled result holds the block further
// reset: arst_n clears the filter accumulator and loads the register defaults
`timescale 1ns / 1ps
module altitude_hold_throttle_pitch (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_wr_en,
	input  logic [2:0]          cfg_index,
	input  logic [15:0]         cfg_data,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [15:0]         pulse_in,
	input  logic                hold_enable,
	input  logic                waypoint_mode,
	input  logic signed [15:0]  waypoint_height,
	input  logic signed [15:0]  current_height,
	input  logic                full_throttle_override,
	output logic                out_valid,
	input  logic                out_stall,
	output logic signed [15:0]  throttle_control,
	output logic signed [15:0]  pitch_adjust
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_STK  = 3'd1;
	localparam logic [2:0] ST_MT   = 3'd2;
	localparam logic [2:0] ST_ERR  = 3'd3;
	localparam logic [2:0] ST_MP   = 3'd4;
	localparam logic [2:0] ST_ACC  = 3'd5;
	localparam logic [2:0] ST_UPD  = 3'd6;
	localparam logic [2:0] ST_OUT  = 3'd7;

	localparam int unsigned SW = alhtp_pkg::STICK_W;
	localparam int unsigned GW = alhtp_pkg::GAIN_W;
	localparam int unsigned NW = alhtp_pkg::NERR_W;
	localparam int unsigned PW = alhtp_pkg::PULSE_W;
	localparam int unsigned FS = alhtp_pkg::FILT_SHIFT;
	localparam int unsigned SS = alhtp_pkg::STICK_SHIFT;
	localparam logic [3:0] MT_LAST = 4'(GW - 1);
	localparam logic [3:0] MP_LAST = 4'(NW - 1);

	// configuration
	logic [11:0]        trim_q;
	logic               rev_q;
	logic [11:0]        max_q;
	logic [14:0]        thr_ph_q;
	logic [14:0]        gain_q;
	logic signed [15:0] pit_max_q;
	logic signed [15:0] pit_zero_q;
	logic signed [15:0] pit_ph_q;

	// sequencer and item registers
	logic [2:0]          state_q;
	logic [3:0]          cnt_q;
	logic [15:0]         pulse_q;
	logic                hold_q;
	logic                wpmode_q;
	logic signed [15:0]  wp_q;
	logic signed [15:0]  cur_q;
	logic                ovr_q;
	logic signed [SW-1:0] stick_q;
	logic [1:0]          cls_q;
	logic [PW-1:0]       ftgt_q;
	logic signed [15:0]  pit_q;
	logic [31:0]         acc_q;

	alhtp_pkg::mul_ctl_t mt_ctl;
	alhtp_pkg::mul_ctl_t mp_ctl;
	logic signed [SW+GW:0] mt_prod;
	logic signed [16+NW:0] thr_prod;
	logic signed [16+NW:0] pit_prod;

	logic [PW-1:0]        sp_c;
	logic [PW-1:0]        st_c;
	logic signed [SW-1:0] diff_c;
	logic signed [SW-1:0] stick_c;
	logic signed [15:0]   tgt_c;
	logic signed [17:0]   err_c;
	logic signed [17:0]   nerr_full;
	logic [NW-1:0]        nerr_c;
	logic [1:0]           cls_c;
	logic signed [22:0]   max_ext;
	logic signed [22:0]   accum_c;
	logic signed [23:0]   v_c;
	logic [PW-1:0]        vsat_c;
	logic signed [15:0]   pitch_c;
	logic signed [17:0]   fdiff_c;
	logic [19:0]          acc_hi_c;
	logic [15:0]          ctl_c;

	assign in_stall = (state_q != ST_IDLE);

	// stick value
	assign sp_c    = alhtp_pkg::sat_pulse(pulse_q);
	assign st_c    = alhtp_pkg::sat_pulse({4'd0, trim_q});
	assign diff_c  = $signed({1'b0, sp_c}) - $signed({1'b0, st_c});
	assign stick_c = rev_q ? -diff_c : diff_c;

	// height error and band
	assign tgt_c = wpmode_q ? wp_q : mt_prod[SS+15:SS];
	assign err_c = $signed({{2{tgt_c[15]}}, tgt_c}) - $signed({{2{cur_q[15]}}, cur_q})
		- 18'(alhtp_pkg::HEIGHT_MARGIN);
	assign nerr_full = -err_c;
	assign nerr_c    = nerr_full[NW-1:0];

	always_comb begin
		if (err_c > 18'sd0) begin
			cls_c = alhtp_pkg::CLS_BELOW;
		end else if (err_c < -18'(2 * alhtp_pkg::HEIGHT_MARGIN)) begin
			cls_c = alhtp_pkg::CLS_ABOVE;
		end else begin
			cls_c = alhtp_pkg::CLS_MARGIN;
		end
	end

	always_comb begin
		mt_ctl.load = (state_q == ST_STK);
		mt_ctl.step = (state_q == ST_MT);
		mp_ctl.load = (state_q == ST_ERR);
		mp_ctl.step = (state_q == ST_MP);
	end

	alhtp_smul #(.WA(SW), .WB(GW)) u_mul_tgt (
		.clk  (clk),
		.ctl  (mt_ctl),
		.a    (stick_c),
		.b    (gain_q),
		.prod (mt_prod)
	);

	alhtp_smul #(.WA(16), .WB(NW)) u_mul_thr (
		.clk  (clk),
		.ctl  (mp_ctl),
		.a    ($signed({1'b0, thr_ph_q})),
		.b    (nerr_c),
		.prod (thr_prod)
	);

	alhtp_smul #(.WA(16), .WB(NW)) u_mul_pit (
		.clk  (clk),
		.ctl  (mp_ctl),
		.a    (pit_ph_q),
		.b    (nerr_c),
		.prod (pit_prod)
	);

	// throttle offset, filter target and pitch
	assign max_ext = $signed({11'd0, max_q});

	always_comb begin
		case (cls_q)
			alhtp_pkg::CLS_BELOW: begin
				accum_c = max_ext;
				pitch_c = pit_max_q;
			end
			alhtp_pkg::CLS_ABOVE: begin
				accum_c = '0;
				pitch_c = pit_zero_q;
			end
			alhtp_pkg::CLS_MARGIN: begin
				accum_c = max_ext - $signed({thr_prod[16+NW], thr_prod});
				pitch_c = pit_max_q - $signed(pit_prod[15:0]);
			end
			default: begin
				accum_c = '0;
				pitch_c = '0;
			end
		endcase
		if (ovr_q) begin
			accum_c = max_ext;
		end
	end

	assign v_c = $signed({12'd0, trim_q}) - $signed({accum_c[22], accum_c});

	always_comb begin
		if (v_c < $signed({12'd0, alhtp_pkg::PULSE_MIN})) begin
			vsat_c = alhtp_pkg::PULSE_MIN;
		end else if (v_c > $signed({12'd0, alhtp_pkg::PULSE_MAX})) begin
			vsat_c = alhtp_pkg::PULSE_MAX;
		end else begin
			vsat_c = v_c[PW-1:0];
		end
	end

	// filter step on the bits above FILT_SHIFT, driven from the upper word
	assign fdiff_c  = $signed({6'd0, ftgt_q}) - $signed({{2{acc_q[31]}}, acc_q[31:16]});
	assign acc_hi_c = acc_q[31:FS] + {{2{fdiff_c[17]}}, fdiff_c};
	assign ctl_c    = acc_q[31:16] - {4'd0, trim_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			trim_q           <= 12'd3000;
			rev_q            <= 1'b0;
			max_q            <= 12'd1800;
			thr_ph_q         <= 15'd162;
			gain_q           <= 15'd1024;
			pit_max_q        <= '0;
			pit_zero_q       <= '0;
			pit_ph_q         <= '0;
			state_q          <= ST_IDLE;
			cnt_q            <= '0;
			pulse_q          <= '0;
			hold_q           <= 1'b0;
			wpmode_q         <= 1'b0;
			wp_q             <= '0;
			cur_q            <= '0;
			ovr_q            <= 1'b0;
			stick_q          <= '0;
			cls_q            <= alhtp_pkg::CLS_BELOW;
			ftgt_q           <= '0;
			pit_q            <= '0;
			acc_q            <= '0;
			out_valid        <= 1'b0;
			throttle_control <= '0;
			pitch_adjust     <= '0;
		end else begin
			if (cfg_wr_en) begin
				case (cfg_index)
					alhtp_pkg::REG_TRIM:     trim_q     <= cfg_data[11:0];
					alhtp_pkg::REG_REVERSED: rev_q      <= cfg_data[0];
					alhtp_pkg::REG_MAX_THR:  max_q      <= cfg_data[11:0];
					alhtp_pkg::REG_THR_PH:   thr_ph_q   <= cfg_data[14:0];
					alhtp_pkg::REG_GAIN:     gain_q     <= cfg_data[14:0];
					alhtp_pkg::REG_PIT_MAX:  pit_max_q  <= $signed(cfg_data);
					alhtp_pkg::REG_PIT_ZERO: pit_zero_q <= $signed(cfg_data);
					alhtp_pkg::REG_PIT_PH:   pit_ph_q   <= $signed(cfg_data);
					default: ;
				endcase
			end

			if (out_valid && !out_stall && state_q != ST_OUT) begin
				out_valid <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						pulse_q  <= pulse_in;
						hold_q   <= hold_enable;
						wpmode_q <= waypoint_mode;
						wp_q     <= waypoint_height;
						cur_q    <= current_height;
						ovr_q    <= full_throttle_override;
						state_q  <= hold_enable ? ST_STK : ST_OUT;
					end
				end
				ST_STK: begin
					stick_q <= stick_c;
					cnt_q   <= '0;
					state_q <= ST_MT;
				end
				ST_MT: begin
					cnt_q <= cnt_q + 4'd1;
					if (cnt_q == MT_LAST) begin
						state_q <= ST_ERR;
					end
				end
				ST_ERR: begin
					cls_q   <= cls_c;
					cnt_q   <= '0;
					state_q <= ST_MP;
				end
				ST_MP: begin
					cnt_q <= cnt_q + 4'd1;
					if (cnt_q == MP_LAST) begin
						state_q <= ST_ACC;
					end
				end
				ST_ACC: begin
					// deadband relaxes to raw trim
					if (stick_q < SW'(alhtp_pkg::DEADBAND)) begin
						ftgt_q <= trim_q;
						pit_q  <= '0;
					end else begin
						ftgt_q <= vsat_c;
						pit_q  <= pitch_c;
					end
					state_q <= ST_UPD;
				end
				ST_UPD: begin
					acc_q[31:FS] <= acc_hi_c;
					state_q      <= ST_OUT;
				end
				ST_OUT: begin
					if (!out_valid || !out_stall) begin
						out_valid        <= 1'b1;
						throttle_control <= hold_q ? $signed(ctl_c) : 16'sd0;
						pitch_adjust     <= hold_q ? pit_q : 16'sd0;
						state_q          <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	a_hold_off_skips: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall && !hold_enable) |=> state_q == ST_OUT)
		else $error("hold-off item did not go straight to output");

	a_out_from_seq: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(state_q) == ST_OUT)
		else $error("result raised outside output step");

	a_acc_low_fixed: assert property (@(posedge clk) disable iff (!arst_n)
		$stable(acc_q[FS-1:0]))
		else $error("filter low bits changed");

	a_acc_only_upd: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(acc_q) |-> $past(state_q) == ST_UPD)
		else $error("filter changed outside update step");

endmodule

FILE: rtl/alhtp_smul.sv
`timescale 1ns / 1ps
module alhtp_smul #(
	parameter int unsigned WA = 16,
	parameter int unsigned WB = 5
) (
	input  logic                    clk,
	input  alhtp_pkg::mul_ctl_t     ctl,
	input  logic signed [WA-1:0]    a,
	input  logic        [WB-1:0]    b,
	output logic signed [WA+WB:0]   prod
);

	logic signed [WA-1:0] a_q;
	logic signed [WA:0]   h_q;
	logic        [WB-1:0] l_q;
	logic signed [WA+1:0] sum;

	// one multiplier bit a cycle while ctl.step is set, lsb first
	assign sum = $signed({h_q[WA], h_q})
		+ (l_q[0] ? $signed({{2{a_q[WA-1]}}, a_q}) : $signed({(WA+2){1'b0}}));

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			a_q <= a;
			h_q <= '0;
			l_q <= b;
		end else if (ctl.step) begin
			h_q <= sum[WA+1:1];
			l_q <= {sum[0], l_q[WB-1:1]};
		end
	end

	assign prod = $signed({h_q, l_q});

endmodule

FILE: tb/tb_altitude_hold_throttle_pitch.sv
`timescale 1ns / 1ps
module tb_altitude_hold_throttle_pitch;

	localparam int LONG_HOLD      = 300;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int PHASE_ITEMS    = 64;
	localparam int N_PHASES       = 8;
	localparam int N_DIRECTED     = 20;
	localparam int SETTLE_CYCLES  = 30;

	typedef struct packed {
		logic [15:0] pulse;
		logic        hold;
		logic        mode;
		logic [15:0] wp;
		logic [15:0] cur;
		logic        ovr;
	} tick_t;

	typedef struct packed {
		logic [15:0] thr;
		logic [15:0] pit;
	} command_t;

	typedef struct packed {
		tick_t    t;
		logic     typed;
		command_t res;
	} row_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               cfg_wr_en = 1'b0;
	logic [2:0]         cfg_index = '0;
	logic [15:0]        cfg_data = '0;
	logic               in_valid = 1'b0;
	logic               in_stall;
	logic [15:0]        pulse_in = '0;
	logic               hold_enable = 1'b0;
	logic               waypoint_mode = 1'b0;
	logic signed [15:0] waypoint_height = '0;
	logic signed [15:0] current_height = '0;
	logic               full_throttle_override = 1'b0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic signed [15:0] throttle_control;
	logic signed [15:0] pitch_adjust;

	// own copy of the registers and the filter
	logic [11:0] trim_r;
	logic        rev_r;
	logic [11:0] max_thr_r;
	logic [14:0] thr_ph_r;
	logic [14:0] gain_r;
	logic [15:0] pit_max_r;
	logic [15:0] pit_zero_r;
	logic [15:0] pit_ph_r;
	logic [31:0] filt_acc;

	command_t queued_commands[$];
	int       errors = 0;
	int       checked = 0;
	int       send_idle_pct = 0;
	int       recv_stall_pct = 0;
	int       hold_req = 0;
	int       hold_seen = 0;
	int       hold_left = 0;
	int       quiet_cycles = 0;
	row_t     dir_rows [N_DIRECTED];

	altitude_hold_throttle_pitch dut (
		.clk                    (clk),
		.arst_n                 (arst_n),
		.cfg_wr_en              (cfg_wr_en),
		.cfg_index              (cfg_index),
		.cfg_data               (cfg_data),
		.in_valid               (in_valid),
		.in_stall               (in_stall),
		.pulse_in               (pulse_in),
		.hold_enable            (hold_enable),
		.waypoint_mode          (waypoint_mode),
		.waypoint_height        (waypoint_height),
		.current_height         (current_height),
		.full_throttle_override (full_throttle_override),
		.out_valid              (out_valid),
		.out_stall              (out_stall),
		.throttle_control       (throttle_control),
		.pitch_adjust           (pitch_adjust)
	);

	always #4 clk = ~clk;

	function automatic longint sx16(input logic [15:0] v);
		logic signed [15:0] s;
		s = v;
		return longint'(s);
	endfunction

	function automatic longint clamp_pulse(input longint v);
		if (v < longint'(alhtp_pkg::PULSE_MIN)) return longint'(alhtp_pkg::PULSE_MIN);
		if (v > longint'(alhtp_pkg::PULSE_MAX)) return longint'(alhtp_pkg::PULSE_MAX);
		return v;
	endfunction

	function automatic longint stick_value(input logic [15:0] pulse);
		longint s;
		s = clamp_pulse(longint'(pulse)) - clamp_pulse(longint'(trim_r));
		if (rev_r) s = -s;
		return s;
	endfunction

	function automatic longint target_height(input logic [15:0] pulse, input logic mode,
			input logic [15:0] wp);
		longint g;
		longint p;
		logic [63:0] bits;
		if (mode) return sx16(wp);
		g = longint'(gain_r);
		p = (g * stick_value(pulse)) >>> alhtp_pkg::STICK_SHIFT;
		bits = 64'(p);
		return sx16(bits[15:0]);
	endfunction

	function automatic void filter_toward(input longint goal);
		longint diff;
		logic [63:0] sh;
		diff = goal - sx16(filt_acc[31:16]);
		sh = 64'(diff) << alhtp_pkg::FILT_SHIFT;
		filt_acc = filt_acc + sh[31:0];
	endfunction

	function automatic command_t hold_law(input tick_t t);
		command_t r;
		longint stick, tgt, hgt, offs, err, pit, trim, ctl;
		logic [63:0] pbits, cbits;
		r = '0;
		if (!t.hold) return r;
		trim = longint'(trim_r);
		stick = stick_value(t.pulse);
		tgt = target_height(t.pulse, t.mode, t.wp);
		hgt = sx16(t.cur);
		pit = 0;
		if (stick < alhtp_pkg::DEADBAND) begin
			filter_toward(trim);
		end else begin
			err = tgt - hgt - alhtp_pkg::HEIGHT_MARGIN;
			if (hgt < tgt - alhtp_pkg::HEIGHT_MARGIN) begin
				offs = longint'(max_thr_r);
				pit = sx16(pit_max_r);
			end else if (hgt > tgt + alhtp_pkg::HEIGHT_MARGIN) begin
				offs = 0;
				pit = sx16(pit_zero_r);
			end else begin
				offs = longint'(max_thr_r) + longint'(thr_ph_r) * err;
				pit = sx16(pit_max_r) + sx16(pit_ph_r) * err;
			end
			if (t.ovr) offs = longint'(max_thr_r);
			filter_toward(clamp_pulse(trim - offs));
		end
		ctl = sx16(filt_acc[31:16]) - trim;
		cbits = 64'(ctl);
		pbits = 64'(pit);
		r.thr = cbits[15:0];
		r.pit = pbits[15:0];
		return r;
	endfunction

	function automatic row_t mk(input logic [15:0] p, input logic h, input logic m,
			input logic [15:0] w, input logic [15:0] c, input logic o, input logic typed,
			input logic [15:0] thr, input logic [15:0] pit);
		row_t r;
		r.t = '{pulse: p, hold: h, mode: m, wp: w, cur: c, ovr: o};
		r.typed = typed;
		r.res = '{thr: thr, pit: pit};
		return r;
	endfunction

	function automatic tick_t make_tick();
		tick_t t;
		longint tgt;
		int off;
		t.hold = ($urandom_range(9) != 0);
		t.mode = 1'($urandom_range(1));
		t.ovr = ($urandom_range(4) == 0);
		t.wp = 16'($urandom);
		if ($urandom_range(7) == 0) t.wp = $urandom_range(1) ? 16'h7FFF : 16'h8000;
		off = int'($urandom_range(6)) - 3;
		case ($urandom_range(9))
			0: t.pulse = 16'($urandom);
			1: begin
				case ($urandom_range(3))
					0: t.pulse = 16'h0000;
					1: t.pulse = 16'hFFFF;
					2: t.pulse = 16'd2000;
					default: t.pulse = 16'd4000;
				endcase
			end
			2: t.pulse = 16'(clamp_pulse(longint'(trim_r)) + (rev_r ? -150 : 150) + off);
			default: t.pulse = 16'(2000 + $urandom_range(2000));
		endcase
		tgt = target_height(t.pulse, t.mode, t.wp);
		off = int'($urandom_range(24)) - 12;
		if ($urandom_range(9) < 7) t.cur = 16'(tgt + off);
		else t.cur = 16'($urandom);
		return t;
	endfunction

	task automatic report_mismatch(input string msg);
		$display("mismatch at result %0d: %s", checked, msg);
		errors++;
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
	endtask

	task automatic load_settings(input logic [11:0] trim, input logic rev,
			input logic [11:0] mx, input logic [14:0] tph, input logic [14:0] gain,
			input logic [15:0] pmax, input logic [15:0] pzero, input logic [15:0] pph);
		write_reg(alhtp_pkg::REG_TRIM, {4'd0, trim});
		write_reg(alhtp_pkg::REG_REVERSED, {15'd0, rev});
		write_reg(alhtp_pkg::REG_MAX_THR, {4'd0, mx});
		write_reg(alhtp_pkg::REG_THR_PH, {1'b0, tph});
		write_reg(alhtp_pkg::REG_GAIN, {1'b0, gain});
		write_reg(alhtp_pkg::REG_PIT_MAX, pmax);
		write_reg(alhtp_pkg::REG_PIT_ZERO, pzero);
		write_reg(alhtp_pkg::REG_PIT_PH, pph);
		cfg_wr_en <= 1'b0;
		trim_r = trim;
		rev_r = rev;
		max_thr_r = mx;
		thr_ph_r = tph;
		gain_r = gain;
		pit_max_r = pmax;
		pit_zero_r = pzero;
		pit_ph_r = pph;
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (queued_commands.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic send_tick(input tick_t t, input logic typed, input command_t res);
		command_t c;
		if ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
		end
		in_valid <= 1'b1;
		pulse_in <= t.pulse;
		hold_enable <= t.hold;
		waypoint_mode <= t.mode;
		waypoint_height <= t.wp;
		current_height <= t.cur;
		full_throttle_override <= t.ovr;
		do @(posedge clk); while (in_stall);
		c = hold_law(t);
		if (typed) c = res;
		queued_commands.push_back(c);
	endtask

	task automatic random_settings(input int phase);
		logic [11:0] trim;
		case ($urandom_range(3))
			0: trim = 12'(2000 + $urandom_range(2000));
			1: trim = 12'($urandom_range(4095));
			2: trim = 12'd2000;
			default: trim = 12'd4000;
		endcase
		case (phase)
			1: load_settings(12'd3000, 1'b0, 12'd1800, 15'd162, 15'd1024,
				16'd400, 16'hFE70, 16'd25);
			2: load_settings(12'd2000, 1'b0, 12'd0, 15'd0, 15'd0,
				16'h8000, 16'h8000, 16'h8000);
			3: load_settings(12'd4000, 1'b1, 12'd4000, 15'h7FFF, 15'h7FFF,
				16'h7FFF, 16'h7FFF, 16'h7FFF);
			4: load_settings(12'd0, 1'b0, 12'hFFF, 15'($urandom_range(400)), 15'd2048,
				16'($urandom), 16'($urandom), 16'($urandom));
			5: load_settings(12'hFFF, 1'b1, 12'($urandom), 15'($urandom_range(400)),
				15'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
			default: load_settings(trim, 1'($urandom_range(1)), 12'($urandom),
				$urandom_range(1) ? 15'($urandom_range(400)) : 15'($urandom),
				15'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
		endcase
	endtask

	// result side
	initial begin
		command_t e;
		forever begin
			@(posedge clk);
			if (out_valid && !out_stall) begin
				if (queued_commands.size() == 0) begin
					report_mismatch("result with nothing outstanding");
				end else begin
					e = queued_commands.pop_front();
					if (throttle_control !== e.thr)
						report_mismatch($sformatf("throttle_control %h, wanted %h",
							throttle_control, e.thr));
					if (pitch_adjust !== e.pit)
						report_mismatch($sformatf("pitch_adjust %h, wanted %h",
							pitch_adjust, e.pit));
				end
				checked++;
			end
			if (hold_seen != hold_req) begin
				hold_seen = hold_req;
				hold_left = LONG_HOLD;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= ($urandom_range(99) < recv_stall_pct);
			end
		end
	end

	initial begin
		while (quiet_cycles < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles = 0;
			else quiet_cycles++;
		end
		$display("tb_altitude_hold_throttle_pitch: FAIL");
		$finish;
	end

	initial begin
		trim_r = 12'd3000;
		rev_r = 1'b0;
		max_thr_r = 12'd1800;
		thr_ph_r = 15'd162;
		gain_r = 15'd1024;
		pit_max_r = '0;
		pit_zero_r = '0;
		pit_ph_r = '0;
		filt_acc = '0;
		dir_rows = '{
			mk(16'h0000, 1'b0, 1'b0, 16'h0000, 16'h0000, 1'b0, 1'b1, 16'h0000, 16'h0000),
			mk(16'hFFFF, 1'b0, 1'b1, 16'h7FFF, 16'h8000, 1'b1, 1'b1, 16'h0000, 16'h0000),
			mk(16'h0000, 1'b1, 1'b0, 16'h0000, 16'h0000, 1'b0, 1'b0, 16'h0, 16'h0),
			mk(16'hFFFF, 1'b1, 1'b0, 16'h0000, 16'h0000, 1'b0, 1'b0, 16'h0, 16'h0),
			mk(16'd2000, 1'b1, 1'b0, 16'h0000, 16'h0000, 1'b0, 1'b0, 16'h0, 16'h0),
			mk(16'd4000, 1'b1, 1'b0, 16'h0000, 16'd500, 1'b0, 1'b0, 16'h0, 16'h0),
			mk(16'd3149, 1'b1, 1'b0, 16'h0000, 16'd70, 1'b0, 1'b0, 16'h0, 16'h0),
			mk(16'd3150, 1'b1, 1'b0, 16'h0000, 16'd65, 1'b0, 1'b0, 16'h0, 16'h0),
			mk(16'd3150, 1'b1, 1'b0, 16'h0000, 16'd85, 1'b0, 1'b0, 16'h0, 16'h0),
			mk(16'd3150, 1'b1, 1'b0, 16'h0000, 16'd64, 1'b0, 1'b0, 16'h0, 16'h0),
			mk(16'd3150, 1'b1, 1'b0, 16'h0000, 16'd86, 1'b0, 1'b0, 16'h0, 16'h0),
			mk(16'd3150, 1'b1, 1'b0, 16'h0000, 16'd75, 1'b1, 1'b0, 16'h0, 16'h0),
			mk(16'd3500, 1'b1, 1'b1, 16'd1000, 16'd995, 1'b0, 1'b0, 16'h0, 16'h0),
			mk(16'd3500, 1'b1, 1'b1, 16'h7FFF, 16'h8000, 1'b0, 1'b0, 16'h0, 16'h0),
			mk(16'd3500, 1'b1, 1'b1, 16'h8000, 16'h7FFF, 1'b0, 1'b0, 16'h0, 16'h0),
			mk(16'd3500, 1'b1, 1'b1, 16'h8000, 16'h8000, 1'b0, 1'b0, 16'h0, 16'h0),
			mk(16'd3500, 1'b1, 1'b1, 16'h7FFF, 16'h7FFF, 1'b1, 1'b0, 16'h0, 16'h0),
			mk(16'd3000, 1'b1, 1'b1, 16'd200, 16'd0, 1'b1, 1'b0, 16'h0, 16'h0),
			mk(16'd3700, 1'b0, 1'b0, 16'h1234, 16'h4321, 1'b1, 1'b1, 16'h0000, 16'h0000),
			mk(16'd4000, 1'b1, 1'b0, 16'h0000, 16'h8000, 1'b1, 1'b0, 16'h0, 16'h0)
		};
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		for (int i = 0; i < N_DIRECTED; i++) send_tick(dir_rows[i].t, dir_rows[i].typed,
			dir_rows[i].res);
		for (int ph = 1; ph <= N_PHASES; ph++) begin
			drain();
			random_settings(ph);
			case (ph % 4)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 72; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 72; end
				default: begin send_idle_pct = 13; recv_stall_pct = 13; end
			endcase
			if (ph == 4) hold_req++;
			for (int n = 0; n < PHASE_ITEMS; n++) send_tick(make_tick(), 1'b0, '0);
		end
		drain();
		if (errors == 0) begin
			$display("tb_altitude_hold_throttle_pitch: PASS");
		end else begin
			$display("tb_altitude_hold_throttle_pitch: FAIL");
		end
		$finish;
	end

endmodule

FILE: filelist.f
rtl/alhtp_pkg.sv
rtl/alhtp_smul.sv
rtl/altitude_hold_throttle_pitch.sv
tb/tb_altitude_hold_throttle_pitch.sv
